>>> hdl/swd_pkg.sv
`timescale 1ns / 1ps
// shared types, constants and helpers of the stepper wave drive sequencer
// used by every module of the block; depends on nothing
package swd_pkg;

   localparam int SWD_COUNT_WIDTH = 16;
   localparam int REG_W           = 16;
   localparam int CSR_ADDR_W      = 5;
   localparam int CSR_DATA_W      = 32;
   localparam int QUEUE_DEPTH     = 2;

   localparam logic [REG_W-1:0] RST_INITIAL_PERIOD = 16'd24999;
   localparam logic [REG_W-1:0] RST_PERIOD_STEP    = 16'd1250;
   localparam logic [REG_W-1:0] RST_MIN_PERIOD     = 16'd1250;
   localparam logic [REG_W-1:0] RST_MAX_PERIOD     = 16'd65535;
   localparam logic [REG_W-1:0] RST_DEBOUNCE_TICKS = 16'd1200;

   typedef enum logic [2:0] {
      REG_INITIAL_PERIOD = 3'd0,
      REG_PERIOD_STEP    = 3'd1,
      REG_MIN_PERIOD     = 3'd2,
      REG_MAX_PERIOD     = 3'd3,
      REG_DEBOUNCE_TICKS = 3'd4
   } reg_index_type;

   typedef enum logic [1:0] {
      SPD_NONE    = 2'd0,
      SPD_SHORTER = 2'd1,
      SPD_LONGER  = 2'd2
   } speed_type;

   localparam logic [3:0] COIL_IN4 = 4'b1000;
   localparam logic [3:0] COIL_IN3 = 4'b0100;
   localparam logic [3:0] COIL_IN2 = 4'b0010;
   localparam logic [3:0] COIL_IN1 = 4'b0001;

   // one queue entry: encoder levels plus the falling-edge tag from the front
   typedef struct packed {
      logic enc_a;
      logic enc_b;
      logic fall;
   } item_type;

   typedef struct packed {
      logic     valid;
      item_type item;
   } q_out_type;

   typedef struct packed {
      logic [REG_W-1:0] period_step;
      logic [REG_W-1:0] min_period;
      logic [REG_W-1:0] max_period;
      logic [REG_W-1:0] debounce_ticks;
   } cfg_type;

   typedef struct packed {
      logic [3:0]       coils;
      logic             step_pulse;
      logic [1:0]       speed_change;
      logic [REG_W-1:0] period_now;
   } result_type;

   // wave drive sequence; anything off the sequence restarts at IN4
   function automatic logic [3:0] next_coils(input logic [3:0] p);
      logic [3:0] n;
      unique case (p)
         COIL_IN4: n = COIL_IN3;
         COIL_IN3: n = COIL_IN2;
         COIL_IN2: n = COIL_IN1;
         default:  n = COIL_IN4;
      endcase
      return n;
   endfunction

endpackage

>>> hdl/stepper_wave_drive_encoder_speed.sv
`timescale 1ns / 1ps
// Stepper wave drive sequencer with encoder speed control. Each req beat is
// one timer tick carrying encoder levels a and b, and yields exactly one rsp
// beat with the coil pattern, step pulse, speed change code and current
// period. The block sustains one beat per clock while rsp_tready is high: the
// front end tags falling edges of a and fills a two-entry queue, and the back
// end updates the whole tick state and holds the result in an output
// register, so rsp_tvalid rises in the cycle after the back end pops its
// beat. A low rsp_tready holds the back end; req_tready falls once the queue
// holds two beats. Registers via the csr port: 0x00 initial period (stored and
// read back only; reset loads RST_INITIAL_PERIOD), 0x04 period step, 0x08 min
// period, 0x0c max period, 0x10 debounce ticks.
module stepper_wave_drive_encoder_speed
   import swd_pkg::*;
#(
   parameter int COUNT_WIDTH = SWD_COUNT_WIDTH
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [7:0]            req_tdata,   // [0] enc_a, [1] enc_b, [7:2] zero
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [23:0]           rsp_tdata,   // [3:0] coils, [4] step_pulse,
                                              // [6:5] speed_change, [22:7] period_now,
                                              // [23] zero
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic [CSR_DATA_W-1:0] csr_prdata,
   output logic                  csr_pready
);

   cfg_type    cfg;
   logic       q_ready;
   logic       q_push;
   item_type   q_item;
   logic       q_pop;
   q_out_type  q_out;
   result_type rsp_data;

   swd_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   swd_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .enc_a      (req_tdata[0]),
      .enc_b      (req_tdata[1]),
      .q_ready    (q_ready),
      .q_push     (q_push),
      .q_item     (q_item)
   );

   swd_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_item (q_item),
      .ready     (q_ready),
      .pop       (q_pop),
      .q_out     (q_out)
   );

   swd_back #(
      .COUNT_WIDTH (COUNT_WIDTH)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg),
      .q_out      (q_out),
      .q_pop      (q_pop),
      .rsp_tready (rsp_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_data   (rsp_data)
   );

   assign rsp_tdata = {1'b0, rsp_data.period_now, rsp_data.speed_change,
                       rsp_data.step_pulse, rsp_data.coils};

endmodule

>>> hdl/swd_csr.sv
`timescale 1ns / 1ps
// apb-style register file for period and debounce settings
// depends on swd_pkg
module swd_csr
   import swd_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic [CSR_DATA_W-1:0] csr_prdata,
   output logic                  csr_pready,
   output cfg_type               cfg
);

   logic [REG_W-1:0] initial_period_ff;
   logic [REG_W-1:0] period_step_ff;
   logic [REG_W-1:0] min_period_ff;
   logic [REG_W-1:0] max_period_ff;
   logic [REG_W-1:0] debounce_ticks_ff;
   logic             wr_en;
   logic [2:0]       reg_idx;
   logic [REG_W-1:0] wdata;

   assign csr_pready = 1'b1;
   assign wr_en      = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign reg_idx    = csr_paddr[4:2];
   assign wdata      = csr_pwdata[REG_W-1:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         initial_period_ff <= RST_INITIAL_PERIOD;
         period_step_ff    <= RST_PERIOD_STEP;
         min_period_ff     <= RST_MIN_PERIOD;
         max_period_ff     <= RST_MAX_PERIOD;
         debounce_ticks_ff <= RST_DEBOUNCE_TICKS;
      end else if (wr_en) begin
         unique case (reg_idx)
            REG_INITIAL_PERIOD: initial_period_ff <= wdata;
            REG_PERIOD_STEP:    period_step_ff    <= wdata;
            REG_MIN_PERIOD:     min_period_ff     <= wdata;
            REG_MAX_PERIOD:     max_period_ff     <= wdata;
            REG_DEBOUNCE_TICKS: debounce_ticks_ff <= wdata;
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (reg_idx)
         REG_INITIAL_PERIOD: csr_prdata = CSR_DATA_W'(initial_period_ff);
         REG_PERIOD_STEP:    csr_prdata = CSR_DATA_W'(period_step_ff);
         REG_MIN_PERIOD:     csr_prdata = CSR_DATA_W'(min_period_ff);
         REG_MAX_PERIOD:     csr_prdata = CSR_DATA_W'(max_period_ff);
         REG_DEBOUNCE_TICKS: csr_prdata = CSR_DATA_W'(debounce_ticks_ff);
         default:            csr_prdata = '0;
      endcase
   end

   assign cfg.period_step    = period_step_ff;
   assign cfg.min_period     = min_period_ff;
   assign cfg.max_period     = max_period_ff;
   assign cfg.debounce_ticks = debounce_ticks_ff;

endmodule

>>> hdl/swd_front.sv
`timescale 1ns / 1ps
// input side: takes encoder beats and tags falling edges on channel a
// depends on swd_pkg; feeds swd_queue
module swd_front
   import swd_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  logic     req_tvalid,
   output logic     req_tready,
   input  logic     enc_a,
   input  logic     enc_b,
   input  logic     q_ready,
   output logic     q_push,
   output item_type q_item
);

   logic a_prev_ff;

   assign req_tready = q_ready;
   assign q_push     = req_tvalid && q_ready;

   assign q_item.enc_a = enc_a;
   assign q_item.enc_b = enc_b;
   assign q_item.fall  = a_prev_ff && !enc_a;

   // channel a is pulled up, so the history starts high
   always_ff @(posedge clock) begin
      if (reset) begin
         a_prev_ff <= 1'b1;
      end else if (q_push) begin
         a_prev_ff <= enc_a;
      end
   end

endmodule

>>> hdl/swd_queue.sv
`timescale 1ns / 1ps
// short queue between the front and the back end
// depends on swd_pkg
module swd_queue
   import swd_pkg::*;
(
   input  logic      clock,
   input  logic      reset,
   input  logic      push,
   input  item_type  push_item,
   output logic      ready,
   input  logic      pop,
   output q_out_type q_out
);

   localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

   item_type         mem [QUEUE_DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff;
   logic [PTR_W-1:0] rd_ptr_ff;
   logic [CNT_W-1:0] cnt_ff;
   logic [PTR_W-1:0] wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_in;
   logic [CNT_W-1:0] cnt_in;

   assign ready       = (cnt_ff != CNT_W'(QUEUE_DEPTH));
   assign q_out.valid = (cnt_ff != '0);
   assign q_out.item  = mem[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      cnt_in    = cnt_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         cnt_in = cnt_ff + 1'b1;
      end else if (pop && !push) begin
         cnt_in = cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem[wr_ptr_ff] <= push_item;
      end
   end

   a_cnt_bound: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= CNT_W'(QUEUE_DEPTH))
      else $error("queue fill count out of range");

   a_pop_nonempty: assert property (@(posedge clock) disable iff (reset)
      pop |-> cnt_ff != '0)
      else $error("pop from empty queue");

   a_push_grows: assert property (@(posedge clock) disable iff (reset)
      push && !pop |=> cnt_ff == $past(cnt_ff) + 1'b1)
      else $error("queue count did not follow a push");

endmodule

>>> hdl/swd_back.sv
`timescale 1ns / 1ps
// back end: debounce, period adjust, step timer, coil sequence, result register
// depends on swd_pkg; pops items from swd_queue
module swd_back
   import swd_pkg::*;
#(
   parameter int COUNT_WIDTH = SWD_COUNT_WIDTH
) (
   input  logic       clock,
   input  logic       reset,
   input  cfg_type    cfg,
   input  q_out_type  q_out,
   output logic       q_pop,
   input  logic       rsp_tready,
   output logic       rsp_tvalid,
   output result_type rsp_data
);

   localparam int CMP_W = (COUNT_WIDTH > REG_W) ? COUNT_WIDTH : REG_W;

   logic [COUNT_WIDTH-1:0] tick_ff;
   logic [COUNT_WIDTH-1:0] tick_in;
   logic [COUNT_WIDTH-1:0] deb_cnt_ff;
   logic [COUNT_WIDTH-1:0] deb_cnt_in;
   logic                   deb_active_ff;
   logic                   deb_active_in;
   logic [REG_W-1:0]       period_ff;
   logic [REG_W-1:0]       period_in;
   logic [3:0]             coil_ff;
   logic [3:0]             coil_in;
   logic                   rsp_valid_ff;
   result_type             rsp_data_ff;
   result_type             rsp_data_in;

   logic                   deb_done;
   logic [REG_W:0]         diff;
   logic [REG_W:0]         sum;
   logic                   under_floor;
   logic                   over_ceil;
   logic                   step_now;
   logic [1:0]             change;

   assign q_pop      = q_out.valid && (!rsp_valid_ff || rsp_tready);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_data   = rsp_data_ff;

   assign deb_done = (CMP_W'(deb_cnt_ff) >= CMP_W'(cfg.debounce_ticks)) || (&deb_cnt_ff);

   assign diff        = {1'b0, period_ff} - {1'b0, cfg.period_step};
   assign sum         = {1'b0, period_ff} + {1'b0, cfg.period_step};
   assign under_floor = diff[REG_W] || (diff[REG_W-1:0] < cfg.min_period);
   assign over_ceil   = sum > {1'b0, cfg.max_period};

   always_comb begin
      deb_active_in = deb_active_ff;
      deb_cnt_in    = deb_cnt_ff;
      period_in     = period_ff;
      change        = SPD_NONE;
      if (deb_active_ff) begin
         if (deb_done) begin
            deb_active_in = 1'b0;
            deb_cnt_in    = '0;
            // detent counts only if a is still low at the end of the wait
            if (!q_out.item.enc_a) begin
               if (!q_out.item.enc_b) begin
                  period_in = under_floor ? cfg.min_period : diff[REG_W-1:0];
                  change    = SPD_SHORTER;
               end else begin
                  period_in = over_ceil ? cfg.max_period : sum[REG_W-1:0];
                  change    = SPD_LONGER;
               end
            end
         end else begin
            deb_cnt_in = deb_cnt_ff + 1'b1;
         end
      end else if (q_out.item.fall) begin
         deb_active_in = 1'b1;
         deb_cnt_in    = '0;
      end

      // step timer compares against the period just updated
      step_now = (CMP_W'(tick_ff) >= CMP_W'(period_in)) || (&tick_ff);
      if (step_now) begin
         tick_in = '0;
         coil_in = next_coils(coil_ff);
      end else begin
         tick_in = tick_ff + 1'b1;
         coil_in = coil_ff;
      end

      rsp_data_in.coils        = coil_in;
      rsp_data_in.step_pulse   = step_now;
      rsp_data_in.speed_change = change;
      rsp_data_in.period_now   = period_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tick_ff       <= '0;
         deb_cnt_ff    <= '0;
         deb_active_ff <= 1'b0;
         period_ff     <= RST_INITIAL_PERIOD;
         coil_ff       <= '0;
      end else if (q_pop) begin
         tick_ff       <= tick_in;
         deb_cnt_ff    <= deb_cnt_in;
         deb_active_ff <= deb_active_in;
         period_ff     <= period_in;
         coil_ff       <= coil_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (q_pop) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (q_pop) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   a_step_onehot: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_data_ff.step_pulse |-> $onehot(rsp_data_ff.coils))
      else $error("step pulse with coil pattern off the sequence");

   a_deb_ends: assert property (@(posedge clock) disable iff (reset)
      q_pop && deb_active_ff && deb_done |=> !deb_active_ff)
      else $error("debounce wait did not end");

   a_no_edge_idle: assert property (@(posedge clock) disable iff (reset)
      q_pop && !deb_active_ff && !q_out.item.fall |=> !deb_active_ff)
      else $error("debounce started without a falling edge");

endmodule

>>> dv/stepper_wave_drive_encoder_speed_test.sv
`timescale 1ns / 1ps
// self-checking bench for stepper_wave_drive_encoder_speed: encoder ticks are sent over
// req, predicted coil / period results are checked against rsp beat by beat
// depends on swd_pkg and the stepper_wave_drive_encoder_speed rtl
module stepper_wave_drive_encoder_speed_test;
   import swd_pkg::*;

   localparam int IDLE_LIMIT = 4000;

   typedef struct packed {
      logic a;
      logic b;
   } enc_levels_type;

   typedef struct packed {
      logic [3:0]  coils;
      logic        step_pulse;
      speed_type   speed_change;
      logic [15:0] period_now;
   } motor_out_type;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [7:0]            req_tdata = '0;    // [0] enc_a, [1] enc_b, [7:2] zero
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b1;
   logic [23:0]           rsp_tdata;         // [3:0] coils, [4] step_pulse,
                                             // [6:5] speed_change, [22:7] period_now, [23] zero
   logic                  csr_psel = 1'b0;
   logic                  csr_penable = 1'b0;
   logic                  csr_pwrite = 1'b0;
   logic [CSR_ADDR_W-1:0] csr_paddr = '0;
   logic [CSR_DATA_W-1:0] csr_pwdata = '0;
   logic [CSR_DATA_W-1:0] csr_prdata;
   logic                  csr_pready;

   stepper_wave_drive_encoder_speed DUT (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready), .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata),
      .csr_psel(csr_psel), .csr_penable(csr_penable), .csr_pwrite(csr_pwrite),
      .csr_paddr(csr_paddr), .csr_pwdata(csr_pwdata), .csr_prdata(csr_prdata),
      .csr_pready(csr_pready)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // predicted motor state and register copies
   logic [15:0] period_step   = RST_PERIOD_STEP;
   logic [15:0] floor_period  = RST_MIN_PERIOD;
   logic [15:0] ceil_period   = RST_MAX_PERIOD;
   logic [15:0] bounce_limit  = RST_DEBOUNCE_TICKS;
   logic [15:0] tick_cnt      = '0;
   logic [15:0] period_val    = RST_INITIAL_PERIOD;
   logic [3:0]  coil_state    = '0;
   logic [15:0] bounce_cnt    = '0;
   logic        bouncing      = 1'b0;
   logic        a_prev        = 1'b1;

   enc_levels_type tick_queue[$];
   motor_out_type  expected_outputs[$];

   int ticks_sent     = 0;
   int ticks_checked  = 0;
   int steps_seen     = 0;
   int speed_changes  = 0;
   int settings_done  = 0;
   int failures       = 0;
   int idle_cycles    = 0;
   logic steady;

   // one stretch of traffic with both sides always ready
   assign steady = (ticks_sent >= 250 && ticks_sent < 420);

   function automatic motor_out_type advance_motor(logic a, logic b);
      motor_out_type o;
      logic [16:0] sum;
      o.speed_change = SPD_NONE;
      o.step_pulse   = 1'b0;
      // debounce runs first so a period change hits this tick's compare
      if (bouncing) begin
         if (bounce_cnt >= bounce_limit || bounce_cnt == '1) begin
            bouncing   = 1'b0;
            bounce_cnt = '0;
            if (!a) begin
               if (!b) begin
                  if (period_val < period_step || period_val - period_step < floor_period)
                     period_val = floor_period;
                  else
                     period_val = period_val - period_step;
                  o.speed_change = SPD_SHORTER;
               end else begin
                  sum = {1'b0, period_val} + {1'b0, period_step};
                  period_val = (sum > {1'b0, ceil_period}) ? ceil_period : sum[15:0];
                  o.speed_change = SPD_LONGER;
               end
            end
         end else begin
            bounce_cnt = bounce_cnt + 16'd1;
         end
      end else if (a_prev && !a) begin
         bouncing   = 1'b1;
         bounce_cnt = '0;
      end
      a_prev = a;

      if (tick_cnt >= period_val || tick_cnt == '1) begin
         tick_cnt = '0;
         case (coil_state)
            COIL_IN4: coil_state = COIL_IN3;
            COIL_IN3: coil_state = COIL_IN2;
            COIL_IN2: coil_state = COIL_IN1;
            default:  coil_state = COIL_IN4;
         endcase
         o.step_pulse = 1'b1;
      end else begin
         tick_cnt = tick_cnt + 16'd1;
      end
      o.coils      = coil_state;
      o.period_now = period_val;
      return o;
   endfunction

   // random encoder level
   function automatic logic coin();
      return 1'($urandom_range(0, 1));
   endfunction

   // driver: presents the head of tick_queue, predicts on each accepted beat
   always @(posedge clock) begin
      if (!reset) begin
         if (req_tvalid && req_tready) begin
            expected_outputs.push_back(advance_motor(tick_queue[0].a, tick_queue[0].b));
            void'(tick_queue.pop_front());
            ticks_sent++;
         end
         if (req_tvalid && !req_tready) begin
            // hold the beat until taken
         end else if (tick_queue.size() > 0 && (steady || $urandom_range(0, 99) >= 24)) begin
            req_tvalid <= 1'b1;
            req_tdata  <= {6'b0, tick_queue[0].b, tick_queue[0].a};
         end else begin
            req_tvalid <= 1'b0;
         end
      end
   end

   // monitor: compares each rsp beat with the oldest prediction
   always @(posedge clock) begin
      motor_out_type exp_out;
      if (!reset) begin
         if (rsp_tvalid && rsp_tready) begin
            if (expected_outputs.size() == 0) begin
               failures++;
               $error("rsp beat with no tick pending: %h", rsp_tdata);
            end else begin
               exp_out = expected_outputs.pop_front();
               ticks_checked++;
               if (exp_out.step_pulse) steps_seen++;
               if (exp_out.speed_change != SPD_NONE) speed_changes++;
               if (rsp_tdata[3:0] !== exp_out.coils) begin
                  failures++;
                  $error("coils: expected %b, actual %b", exp_out.coils, rsp_tdata[3:0]);
               end
               if (rsp_tdata[4] !== exp_out.step_pulse) begin
                  failures++;
                  $error("step_pulse: expected %0d, actual %0d",
                         exp_out.step_pulse, rsp_tdata[4]);
               end
               if (rsp_tdata[6:5] !== exp_out.speed_change) begin
                  failures++;
                  $error("speed_change: expected %0d, actual %0d",
                         exp_out.speed_change, rsp_tdata[6:5]);
               end
               if (rsp_tdata[22:7] !== exp_out.period_now) begin
                  failures++;
                  $error("period_now: expected %0d, actual %0d",
                         exp_out.period_now, rsp_tdata[22:7]);
               end
               if (rsp_tdata[23] !== 1'b0) begin
                  failures++;
                  $error("pad bit: expected 0, actual %b", rsp_tdata[23]);
               end
            end
         end
         rsp_tready <= steady || ($urandom_range(0, 99) >= 24);
      end
   end

   // watchdog on cycles where no beat or register write goes through
   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) ||
          (csr_psel && csr_penable) || reset) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
         $display("timeout: %0d ticks pending", expected_outputs.size());
         $display("simulation failed");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   task automatic write_reg(reg_index_type idx, logic [15:0] value);
      @(posedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= {idx, 2'b00};
      csr_pwdata  <= {16'b0, value};
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      // register takes the value at this edge
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      case (idx)
         REG_INITIAL_PERIOD: ;  // not used by the design; reset loads a constant
         REG_PERIOD_STEP:    period_step  = value;
         REG_MIN_PERIOD:     floor_period = value;
         REG_MAX_PERIOD:     ceil_period  = value;
         REG_DEBOUNCE_TICKS: bounce_limit = value;
         default: ;
      endcase
   endtask

   task automatic load_setting(logic [15:0] init_p, logic [15:0] step_p,
                               logic [15:0] lo_p, logic [15:0] hi_p, logic [15:0] wait_p);
      write_reg(REG_INITIAL_PERIOD, init_p);
      write_reg(REG_PERIOD_STEP, step_p);
      write_reg(REG_MIN_PERIOD, lo_p);
      write_reg(REG_MAX_PERIOD, hi_p);
      write_reg(REG_DEBOUNCE_TICKS, wait_p);
      settings_done++;
   endtask

   // wait until every queued tick has been sent and answered
   task automatic drain();
      do @(negedge clock);
      while (tick_queue.size() != 0 || expected_outputs.size() != 0 || req_tvalid);
   endtask

   task automatic push_tick(logic a, logic b);
      enc_levels_type t;
      t.a = a;
      t.b = b;
      tick_queue.push_back(t);
   endtask

   // mostly complete detents with bouncing inside the wait, some line noise
   task automatic fill_random(int count);
      int pushed;
      int lead;
      pushed = 0;
      while (pushed < count) begin
         if ($urandom_range(0, 99) < 75) begin
            lead = $urandom_range(1, 3);
            repeat (lead) push_tick(1'b1, coin());
            push_tick(1'b0, coin());
            repeat (bounce_limit) push_tick(coin(), coin());
            push_tick(($urandom_range(0, 9) < 8) ? 1'b0 : 1'b1, coin());
            pushed += lead + 2 + bounce_limit;
         end else begin
            lead = $urandom_range(1, 5);
            repeat (lead) push_tick(coin(), coin());
            pushed += lead;
         end
      end
   endtask

   initial begin
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // short wait, huge step: detents jump between floor and ceiling
      load_setting(16'd1, 16'd65535, 16'd1, 16'd65535, 16'd1);
      push_tick(1'b1, 1'b0);
      push_tick(1'b1, 1'b1);
      push_tick(1'b0, 1'b0);   // falling edge
      push_tick(1'b0, 1'b1);
      push_tick(1'b0, 1'b0);   // a low, b low: shorten below zero, clamp to floor
      push_tick(1'b1, 1'b0);
      push_tick(1'b0, 1'b1);   // falling edge
      push_tick(1'b1, 1'b0);   // bounce inside the wait is ignored
      push_tick(1'b0, 1'b1);   // b high: lengthen past ceiling, clamp
      push_tick(1'b1, 1'b1);
      push_tick(1'b0, 1'b0);
      push_tick(1'b0, 1'b0);
      push_tick(1'b1, 1'b1);   // a back high at end of wait: no change
      push_tick(1'b0, 1'b0);
      push_tick(1'b0, 1'b0);
      push_tick(1'b0, 1'b0);   // shorten from ceiling straight to floor
      push_tick(1'b1, 1'b1);
      push_tick(1'b1, 1'b1);
      push_tick(1'b1, 1'b0);
      push_tick(1'b0, 1'b1);
      fill_random(150);
      drain();

      load_setting(16'd65535, 16'd3, 16'd2, 16'd12, 16'd2);
      fill_random(150);
      drain();

      // floor above ceiling
      load_setting(16'd300, 16'd5, 16'd9, 16'd4, 16'd3);
      fill_random(100);
      drain();

      // widest settings; the long wait is left running into the next setting
      load_setting(16'd1, 16'd0, 16'd65535, 16'd65535, 16'd65535);
      push_tick(1'b1, 1'b1);
      push_tick(1'b1, 1'b0);
      push_tick(1'b0, 1'b1);
      repeat (30) push_tick(coin(), coin());
      drain();

      load_setting(16'd40000, 16'd1, 16'd1, 16'd6, 16'd1);
      fill_random(150);
      drain();

      repeat (10) @(posedge clock);
      $display("%0d ticks checked over %0d register settings", ticks_checked, settings_done);
      $display("%0d coil steps and %0d speed changes seen", steps_seen, speed_changes);
      if (failures == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule
